// ----- sv/btg_pkg.sv -----
// ----------------------------------------------------------------------------
// btg_pkg
// Shared types, constants and the sine table of the bell tone generator.
// ----------------------------------------------------------------------------
package btg_pkg;

  localparam logic [17:0] MIXER_RATE_RESET = 18'd48000;
  localparam logic [15:0] MIN_PITCH        = 16'd20;
  localparam logic [6:0]  VOLUME_MAX       = 7'd100;

  // floor(x / 1000) = floor((x >> 3) * DIV_MAGIC >> DIV_SHIFT) for x < 2^34
  localparam int          DIV_PRE_SHIFT    = 3;
  localparam int          DIV_SHIFT        = 38;
  localparam logic [31:0] DIV_MAGIC        = 32'd2199023256;

  localparam int          COUNT_W          = 25;

  localparam logic        OP_START         = 1'b0;
  localparam logic        OP_TICK          = 1'b1;

  localparam logic [1:0]  STATUS_STARTED     = 2'd0;
  localparam logic [1:0]  STATUS_ZERO_PERIOD = 2'd1;
  localparam logic [1:0]  STATUS_POLLED      = 2'd2;
  localparam logic [1:0]  STATUS_TICK        = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [15:0] pitch_hz;
    logic [15:0] period_ms;
    logic [6:0]  volume_pct;
    logic        polled;
  } btg_req_t;

  typedef struct packed {
    logic [17:0]        play_rate;
    logic [23:0]        sample_total;
    logic [1:0]         start_status;
    logic signed [15:0] sample;
    logic               sample_valid;
    logic               last_sample;
  } btg_rsp_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [17:0]        rate;
    logic [1:0]         step_log;
    logic [6:0]         volume;
    logic [COUNT_W-1:0] count;
  } btg_job_t;

  function automatic logic signed [24:0] wave_point(input logic [3:0] idx);
    logic signed [24:0] val;
    case (idx)
      4'd0:    val = 25'sd0;
      4'd1:    val = 25'sd4930687;
      4'd2:    val = 25'sd9110723;
      4'd3:    val = 25'sd11903733;
      4'd4:    val = 25'sd12884508;
      4'd5:    val = 25'sd11903733;
      4'd6:    val = 25'sd9110723;
      4'd7:    val = 25'sd4930687;
      4'd8:    val = 25'sd0;
      4'd9:    val = -25'sd4930688;
      4'd10:   val = -25'sd9110724;
      4'd11:   val = -25'sd11903734;
      4'd12:   val = -25'sd12884509;
      4'd13:   val = -25'sd11903734;
      4'd14:   val = -25'sd9110724;
      4'd15:   val = -25'sd4930688;
      default: val = 25'sd0;
    endcase
    return val;
  endfunction

endpackage

// ----- sv/btg_req_if.sv -----
// ----------------------------------------------------------------------------
// btg_req_if
// Request channel: start and tick transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface btg_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] pitch_hz;
  logic [15:0] period_ms;
  logic [6:0]  volume_pct;
  logic        polled;

  modport source (
    output valid, operation, pitch_hz, period_ms, volume_pct, polled,
    input  ready
  );

  modport sink (
    input  valid, operation, pitch_hz, period_ms, volume_pct, polled,
    output ready
  );
endinterface

// ----- sv/btg_rsp_if.sv -----
// ----------------------------------------------------------------------------
// btg_rsp_if
// Result channel: one result transaction per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface btg_rsp_if;
  logic               valid;
  logic               ready;
  logic [17:0]        play_rate;
  logic [23:0]        sample_total;
  logic [1:0]         start_status;
  logic signed [15:0] sample;
  logic               sample_valid;
  logic               last_sample;

  modport source (
    output valid, play_rate, sample_total, start_status, sample, sample_valid,
           last_sample,
    input  ready
  );

  modport sink (
    input  valid, play_rate, sample_total, start_status, sample, sample_valid,
           last_sample,
    output ready
  );
endinterface

// ----- sv/btg_rate_pipe.sv -----
// ----------------------------------------------------------------------------
// btg_rate_pipe
// Input register, mode select, play rate and bell length in samples
// (rate * period / 1000 through a reciprocal multiply), with per-stage stall.
// ----------------------------------------------------------------------------
module btg_rate_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [17:0]       cfg_wdata,
  input  logic              req_valid,
  output logic              req_ready,
  input  btg_pkg::btg_req_t req,
  output logic              job_valid,
  input  logic              job_ready,
  output btg_pkg::btg_job_t job
);
  import btg_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] rate;
    logic [1:0]  step_log;
    logic [6:0]  volume;
    logic [15:0] period;
  } s1_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [17:0] rate;
    logic [1:0]  step_log;
    logic [6:0]  volume;
    logic [33:0] product;
  } s2_t;

  logic [17:0] mixer_rate;
  btg_req_t    s0;
  s1_t         s1, s1_next;
  s2_t         s2, s2_next;
  btg_job_t    s3_next;
  logic        v0, v1, v2;
  logic        adv0, adv1, adv2, adv3;

  logic [17:0] pitch_ext;
  logic [17:0] pitch_cap;
  logic [19:0] rate_wide;
  logic [2:0]  rate_shift;
  logic [62:0] quot_wide;

  function automatic logic [17:0] req_pitch_min(input logic [15:0] pitch);
    return {2'b00, (pitch < MIN_PITCH) ? MIN_PITCH : pitch};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mixer_rate <= MIXER_RATE_RESET;
    end else if (cfg_we) begin
      mixer_rate <= cfg_wdata;
    end
  end

  assign adv3      = !job_valid || job_ready;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign adv0      = !v0 || adv1;
  assign req_ready = adv0;

  // mode select and play rate
  always_comb begin
    s1_next   = '0;
    pitch_ext = (req_pitch_min(s0.pitch_hz));
    pitch_cap = pitch_ext;
    if (pitch_ext <= (mixer_rate >> 4)) begin
      s1_next.step_log = 2'd0;
    end else if (pitch_ext <= (mixer_rate >> 3)) begin
      s1_next.step_log = 2'd1;
    end else if (pitch_ext <= (mixer_rate >> 2)) begin
      s1_next.step_log = 2'd2;
    end else begin
      s1_next.step_log = 2'd3;
      if (pitch_ext > (mixer_rate >> 1)) begin
        pitch_cap = mixer_rate >> 1;
      end
    end
    rate_shift     = 3'd4 - {1'b0, s1_next.step_log};
    rate_wide      = {2'b00, pitch_cap} << rate_shift;
    s1_next.rate   = rate_wide[17:0];
    s1_next.period = s0.period_ms;
    s1_next.volume = (s0.volume_pct > VOLUME_MAX) ? VOLUME_MAX : s0.volume_pct;
    if (s0.operation == OP_TICK) begin
      s1_next.status = STATUS_TICK;
    end else if (s0.period_ms == 16'd0) begin
      s1_next.status = STATUS_ZERO_PERIOD;
    end else if (s0.polled) begin
      s1_next.status = STATUS_POLLED;
    end else begin
      s1_next.status = STATUS_STARTED;
    end
  end

  always_comb begin
    s2_next          = '0;
    s2_next.status   = s1.status;
    s2_next.rate     = s1.rate;
    s2_next.step_log = s1.step_log;
    s2_next.volume   = s1.volume;
    s2_next.product  = 34'(s1.rate) * 34'(s1.period);
  end

  // divide by 1000: drop three bits, then multiply by the reciprocal of 125
  assign quot_wide = 63'(s2.product[33:DIV_PRE_SHIFT]) * 63'(DIV_MAGIC);

  always_comb begin
    s3_next          = '0;
    s3_next.status   = s2.status;
    s3_next.rate     = s2.rate;
    s3_next.step_log = s2.step_log;
    s3_next.volume   = s2.volume;
    s3_next.count    = quot_wide[DIV_SHIFT +: COUNT_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (adv0) begin
        v0 <= req_valid;
      end
      if (adv1) begin
        v1 <= v0;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        job_valid <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv0 && req_valid) begin
      s0 <= req;
    end
    if (adv1 && v0) begin
      s1 <= s1_next;
    end
    if (adv2 && v1) begin
      s2 <= s2_next;
    end
    if (adv3 && v2) begin
      job <= s3_next;
    end
  end

endmodule

// ----- sv/btg_voice.sv -----
// ----------------------------------------------------------------------------
// btg_voice
// Sample sequencer and result register: arms the bell on start, steps the
// sine table on tick, scales by volume.
// ----------------------------------------------------------------------------
module btg_voice (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  btg_pkg::btg_job_t job,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output btg_pkg::btg_rsp_t rsp
);
  import btg_pkg::*;

  logic [3:0]         phase_index, phase_index_next;
  logic [3:0]         phase_step, phase_step_next;
  logic [23:0]        samples_left, samples_left_next;
  logic [6:0]         scale_volume, scale_volume_next;
  btg_rsp_t           rsp_next;

  logic [3:0]         point_mask;
  logic [COUNT_W-1:0] rounded;
  logic [23:0]        total;
  logic signed [32:0] tick_prod;
  logic               take;

  assign job_ready = !rsp_valid || rsp_ready;
  assign take      = job_valid && job_ready;

  // round up to whole waves, saturate below 2^24
  assign point_mask = 4'hF >> job.step_log;
  assign rounded    = (job.count + COUNT_W'(point_mask)) & ~COUNT_W'(point_mask);
  assign total      = rounded[24] ? ({24{1'b1}} & ~24'(point_mask)) : rounded[23:0];

  assign tick_prod  = wave_point(phase_index) * $signed({1'b0, scale_volume});

  always_comb begin
    phase_index_next      = phase_index;
    phase_step_next       = phase_step;
    samples_left_next     = samples_left;
    scale_volume_next     = scale_volume;
    rsp_next              = '0;
    rsp_next.start_status = job.status;
    case (job.status)
      STATUS_STARTED: begin
        rsp_next.play_rate    = job.rate;
        rsp_next.sample_total = total;
        phase_index_next      = (job.step_log == 2'd3) ? 4'd4 : 4'd0;
        phase_step_next       = 4'd1 << job.step_log;
        samples_left_next     = total;
        scale_volume_next     = job.volume;
      end
      STATUS_TICK: begin
        if (samples_left != 24'd0) begin
          rsp_next.sample       = tick_prod[31:16];
          rsp_next.sample_valid = 1'b1;
          rsp_next.last_sample  = (samples_left == 24'd1);
          samples_left_next     = samples_left - 24'd1;
          phase_index_next      = phase_index + phase_step;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_index  <= 4'd0;
      phase_step   <= 4'd1;
      samples_left <= 24'd0;
      scale_volume <= 7'd0;
      rsp_valid    <= 1'b0;
    end else begin
      if (job_ready) begin
        rsp_valid <= job_valid;
      end
      if (take) begin
        phase_index  <= phase_index_next;
        phase_step   <= phase_step_next;
        samples_left <= samples_left_next;
        scale_volume <= scale_volume_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- sv/bell_tone_generator_unit.sv -----
// ----------------------------------------------------------------------------
// bell_tone_generator_unit
// Bell tone generator on a 16-point sine table.
// ----------------------------------------------------------------------------
// Takes one request transaction per clock when the result side keeps up and
// returns one result transaction per request, in order. Each result passes
// through the bell-length path: input register, mode select, the
// rate-by-period multiply, the reciprocal multiply for the divide by 1000,
// then the sequencer and result register. Each stage stalls only when the
// stage after it is full, so bubbles are squeezed out while a result waits.
// Write mixer_rate only while no transaction is in flight.
// ----------------------------------------------------------------------------
module bell_tone_generator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [17:0] cfg_wdata,
  btg_req_if.sink     request,
  btg_rsp_if.source   result
);
  import btg_pkg::*;

  btg_req_t req;
  btg_job_t job;
  btg_rsp_t rsp;
  logic     job_valid;
  logic     job_ready;

  assign req.operation  = request.operation;
  assign req.pitch_hz   = request.pitch_hz;
  assign req.period_ms  = request.period_ms;
  assign req.volume_pct = request.volume_pct;
  assign req.polled     = request.polled;

  btg_rate_pipe u_rate_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .req       (req),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  btg_voice u_voice (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .rsp_valid (result.valid),
    .rsp_ready (result.ready),
    .rsp       (rsp)
  );

  assign result.play_rate    = rsp.play_rate;
  assign result.sample_total = rsp.sample_total;
  assign result.start_status = rsp.start_status;
  assign result.sample       = rsp.sample;
  assign result.sample_valid = rsp.sample_valid;
  assign result.last_sample  = rsp.last_sample;

endmodule
